// File: rtl/core/ktat_pkg.sv
package ktat_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W =
      $clog2(((CAPACITY > MAX_RESULTS) ? CAPACITY : MAX_RESULTS) + 1);

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned REM_W      = 16;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [REM_W-1:0]  TIMEOUT_RST = 16'd15;
  localparam logic [STEP_W-1:0] STEP_RST    = 8'd5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_DEL  = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_EXPIRED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_STEP    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic lookup;
    logic mark;
    logic select;
    logic emit;
    logic emit_exp;
  } ctrl_cmd_t;

  typedef struct packed {
    func_e func;
    logic  tmo_zero;
    logic  scan_last;
    logic  due_none;
    logic  out_free;
    logic  last_exp;
  } dp_status_t;

endpackage

// File: rtl/core/ktat_if.sv
interface ktat_in_if;
  import ktat_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   key_id;

  modport source (output valid, output func, output key_id, input ready);
  modport sink   (input valid, input func, input key_id, output ready);
endinterface

interface ktat_out_if;
  import ktat_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     expired_id;
  logic                last;

  modport source (output valid, output status, output expired_id, output last, input ready);
  modport sink   (input valid, input status, input expired_id, input last, output ready);
endinterface

// File: rtl/core/ktat_ctrl.sv
module ktat_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ktat_pkg::dp_status_t sts_i,
  output ktat_pkg::ctrl_cmd_t  cmd_o
);
  import ktat_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_LOOKUP   = 8'b0000_0100,
    S_MARK     = 8'b0000_1000,
    S_CHECK    = 8'b0001_0000,
    S_SELECT   = 8'b0010_0000,
    S_EMIT     = 8'b0100_0000,
    S_EMIT_EXP = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.func)
          FUNC_ADD:  state_d = sts_i.tmo_zero ? S_EMIT : S_LOOKUP;
          FUNC_DEL:  state_d = S_LOOKUP;
          FUNC_TICK: state_d = S_MARK;
          default:   state_d = S_EMIT;
        endcase
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (sts_i.scan_last) state_d = S_EMIT;
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (sts_i.scan_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.scan_clr = 1'b1;
        state_d        = sts_i.due_none ? S_EMIT : S_SELECT;
      end
      S_SELECT: begin
        cmd_o.select = 1'b1;
        if (sts_i.scan_last) state_d = S_EMIT_EXP;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_EMIT_EXP: begin
        // hand out the lowest due id, then search again unless it was the final one
        if (sts_i.out_free) begin
          cmd_o.emit_exp = 1'b1;
          state_d        = sts_i.last_exp ? S_IDLE : S_SELECT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/ktat_dp.sv
module ktat_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ktat_pkg::ctrl_cmd_t            cmd_i,
  output ktat_pkg::dp_status_t           sts_o,
  input  logic [ktat_pkg::FUNC_W-1:0]    in_func_i,
  input  logic [ktat_pkg::ID_W-1:0]      in_id_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [ktat_pkg::STATUS_W-1:0]  out_status_o,
  output logic [ktat_pkg::ID_W-1:0]      out_id_o,
  output logic                           out_last_o,
  input  logic                           cfg_we_i,
  input  logic [ktat_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ktat_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ktat_pkg::*;

  // configuration
  logic [REM_W-1:0]  tmo_q;
  logic [STEP_W-1:0] step_q;

  // slot table
  logic [CAPACITY-1:0] slot_valid_q;
  logic [ID_W-1:0]     slot_key_q [CAPACITY];
  logic [REM_W-1:0]    slot_rem_q [CAPACITY];

  // request and scan state
  func_e            func_q;
  logic [ID_W-1:0]  id_q;
  logic [IDX_W-1:0] idx_q;
  logic             found_q, free_q, best_q;
  logic [IDX_W-1:0] found_idx_q, free_idx_q, best_idx_q;
  logic [ID_W-1:0]  best_key_q;
  logic [CAPACITY-1:0] due_q;
  logic [CNT_W-1:0] due_cnt_q, sent_q;

  // result register
  logic                out_valid_q;
  status_e             out_status_q;
  logic [ID_W-1:0]     out_id_q;
  logic                out_last_q;

  logic             scan_step, scan_last, out_free, tmo_zero;
  logic             cur_valid, cur_match, cur_due, last_exp;
  logic [ID_W-1:0]  cur_key;
  logic [REM_W-1:0] cur_rem;
  logic [CNT_W-1:0] sent_inc;

  assign scan_step = cmd_i.lookup | cmd_i.mark | cmd_i.select;
  assign scan_last = (idx_q == IDX_W'(CAPACITY - 1));
  assign cur_valid = slot_valid_q[idx_q];
  assign cur_key   = slot_key_q[idx_q];
  assign cur_rem   = slot_rem_q[idx_q];
  assign cur_match = cur_valid && (cur_key == id_q);
  assign cur_due   = cur_valid && (cur_rem <= {{(REM_W-STEP_W){1'b0}}, step_q});
  assign tmo_zero  = (tmo_q == '0);
  assign out_free  = !out_valid_q || out_ready_i;
  assign sent_inc  = sent_q + CNT_W'(1);
  assign last_exp  = (sent_inc == due_cnt_q) || (sent_inc == CNT_W'(MAX_RESULTS));

  assign sts_o.func      = func_q;
  assign sts_o.tmo_zero  = tmo_zero;
  assign sts_o.scan_last = scan_last;
  assign sts_o.due_none  = (due_cnt_q == '0);
  assign sts_o.out_free  = out_free;
  assign sts_o.last_exp  = last_exp;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_id_o     = out_id_q;
  assign out_last_o   = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q  <= TIMEOUT_RST;
      step_q <= STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_TIMEOUT: tmo_q  <= cfg_wdata_i[REM_W-1:0];
        CFG_STEP:    step_q <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // control-side registers of the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      best_q    <= 1'b0;
      due_cnt_q <= '0;
      sent_q    <= '0;
      due_q     <= '0;
    end else begin
      if (cmd_i.load || cmd_i.scan_clr) begin
        idx_q  <= '0;
        best_q <= 1'b0;
      end else if (scan_step) begin
        idx_q <= scan_last ? '0 : idx_q + IDX_W'(1);
      end
      if (cmd_i.load) begin
        found_q   <= 1'b0;
        free_q    <= 1'b0;
        due_cnt_q <= '0;
        sent_q    <= '0;
      end
      if (cmd_i.lookup) begin
        if (cur_match) found_q <= 1'b1;
        if (!cur_valid) free_q <= 1'b1;
      end
      if (cmd_i.mark) begin
        due_q[idx_q] <= cur_due;
        if (cur_due) due_cnt_q <= due_cnt_q + CNT_W'(1);
      end
      if (cmd_i.select && due_q[idx_q] && (!best_q || cur_key < best_key_q)) begin
        best_q <= 1'b1;
      end
      if (cmd_i.emit_exp) begin
        due_q[best_idx_q] <= 1'b0;
        sent_q            <= sent_inc;
        best_q            <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(in_func_i);
      id_q   <= in_id_i;
    end
    if (cmd_i.lookup) begin
      if (cur_match) found_idx_q <= idx_q;
      // keep the lowest free slot
      if (!cur_valid && !free_q) free_idx_q <= idx_q;
    end
    if (cmd_i.select && due_q[idx_q] && (!best_q || cur_key < best_key_q)) begin
      best_idx_q <= idx_q;
      best_key_q <= cur_key;
    end
  end

  // slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else begin
      if (cmd_i.lookup && cur_match && (func_q == FUNC_DEL)) slot_valid_q[idx_q] <= 1'b0;
      if (cmd_i.emit && (func_q == FUNC_ADD) && !tmo_zero && !found_q && free_q) begin
        slot_valid_q[free_idx_q] <= 1'b1;
      end
      if (cmd_i.emit_exp) slot_valid_q[best_idx_q] <= 1'b0;
    end
  end

  // slot keys and countdowns
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark && cur_valid && !cur_due) begin
      slot_rem_q[idx_q] <= cur_rem - {{(REM_W-STEP_W){1'b0}}, step_q};
    end
    if (cmd_i.emit && (func_q == FUNC_ADD) && !tmo_zero) begin
      if (found_q) begin
        slot_rem_q[found_idx_q] <= tmo_q;
      end else if (free_q) begin
        slot_key_q[free_idx_q] <= id_q;
        slot_rem_q[free_idx_q] <= tmo_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_exp) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_last_q   <= 1'b1;
      out_status_q <= ST_DONE;
      out_id_q     <= '0;
      if (func_q == FUNC_ADD) begin
        if (tmo_zero) begin
          out_status_q <= ST_EXPIRED;
          out_id_q     <= id_q;
        end else if (!found_q && !free_q) begin
          out_status_q <= ST_FULL;
        end
      end
    end else if (cmd_i.emit_exp) begin
      out_last_q   <= last_exp;
      out_status_q <= ST_EXPIRED;
      out_id_q     <= best_key_q;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cmd_i.emit || cmd_i.emit_exp) |-> out_free)
    else $error("result register overwritten while held");

  a_best_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.emit_exp |-> best_q)
    else $error("expiry issued without a due slot");

  a_sent_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      sent_q <= due_cnt_q)
    else $error("more expiries sent than slots due");

  a_exp_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.emit_exp |=> !slot_valid_q[$past(best_idx_q)])
    else $error("expired slot still valid");

endmodule

// File: rtl/core/keyed_timeout_aging_table_top.sv
// Keyed countdown table with timeout aging.
// req_i carries requests: func add/refresh, delete or tick, plus key_id.
// rsp_o carries results: status, expired_id and last. Every request yields
// at least one result and its final result has last set.
// cfg_we_i/cfg_idx_i/cfg_wdata_i write timeout_limit (index 0) or tick_step
// (index 1); write only while no request is in progress.
// Order of work: add and delete scan every table slot once and then load
// the result register. An add with a zero timeout_limit and an unused func
// code skip the scan. A tick first ages every slot, then runs one lowest-id
// search per expired id, and each search walks the slot table through one
// read port. A tick with nothing expiring answers once the aging is done.
// One request is in progress at a time; req_i.ready is high only when idle.
// The result register holds one result: a new request is accepted while it
// waits, and a stalled rsp_o holds the block at its next result.
// Reset empties the table, loads timeout_limit 15 and tick_step 5, and
// drops any pending result.
module keyed_timeout_aging_table_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ktat_in_if.sink                         req_i,
  ktat_out_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [ktat_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ktat_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ktat_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  ktat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ktat_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_func_i    (req_i.func),
    .in_id_i      (req_i.key_id),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .out_status_o (rsp_o.status),
    .out_id_o     (rsp_o.expired_id),
    .out_last_o   (rsp_o.last),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

endmodule
